FILE: hw/rtl/jeo_pkg.sv
package jeo_pkg;

   localparam int MAX_PEOPLE = 32;
   localparam int IDX_W = $clog2(MAX_PEOPLE);
   localparam int CNT_W = $clog2(MAX_PEOPLE + 1);
   localparam int PERSON_W = 6;
   localparam int POS_W = 8;

   typedef struct packed {
      logic [5:0] person_count;
      logic [7:0] start_position;
      logic [7:0] step_count;
   } req_type;

   typedef struct packed {
      logic [5:0] person_number;
      logic       is_survivor;
      logic       last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic init_write;
      logic prime;
      logic load_move;
      logic load_step;
      logic step;
      logic remove;
      logic survivor;
   } jeo_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic init_done;
      logic cnt_zero;
      logic left_gt1;
      logic left_gt2;
   } jeo_status_type;

endpackage

FILE: hw/rtl/jeo_datapath.sv
module jeo_datapath
   import jeo_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  jeo_cmd_type    cmd,
   input  req_type        req_item,
   output jeo_status_type status,
   output rsp_type        rsp_item
);

   logic [IDX_W-1:0] ring_mem [MAX_PEOPLE];

   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] rd_ff;
   logic [POS_W-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0] k_ff, k_in;
   logic [POS_W-1:0] m_ff, m_in;
   rsp_type          rsp_ff, rsp_in;

   logic [CNT_W-1:0] idx_next;
   logic [CNT_W-1:0] req_n;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] init_data;
   logic [PERSON_W-1:0] person;

   assign idx_next  = {{(CNT_W-IDX_W){1'b0}}, idx_ff} + CNT_W'(1);
   assign init_data = (idx_next < n_ff) ? IDX_W'(idx_next) : '0;
   assign rd_addr   = cmd.prime ? '0 : rd_ff;
   assign person    = PERSON_W'({1'b0, cur_ff} + {{IDX_W{1'b0}}, 1'b1});

   // Zero people counts as one; counts above the ring size saturate.
   always_comb begin
      if (req_item.person_count == '0) begin
         req_n = CNT_W'(1);
      end else if (int'(req_item.person_count) > MAX_PEOPLE) begin
         req_n = CNT_W'(MAX_PEOPLE);
      end else begin
         req_n = CNT_W'(req_item.person_count);
      end
   end

   always_comb begin
      n_in    = n_ff;
      left_in = left_ff;
      cur_in  = cur_ff;
      prev_in = prev_ff;
      idx_in  = idx_ff;
      cnt_in  = cnt_ff;
      k_in    = k_ff;
      m_in    = m_ff;
      rsp_in  = rsp_ff;
      if (cmd.load) begin
         n_in    = req_n;
         left_in = req_n;
         cur_in  = '0;
         prev_in = IDX_W'(req_n - CNT_W'(1));
         idx_in  = '0;
         k_in    = req_item.start_position;
         m_in    = req_item.step_count;
      end
      if (cmd.init_write) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.load_move) begin
         cnt_in = (k_ff == '0) ? '0 : k_ff - POS_W'(1);
      end
      if (cmd.load_step) begin
         cnt_in = (m_ff == '0) ? '0 : m_ff - POS_W'(1);
      end
      if (cmd.step) begin
         prev_in = cur_ff;
         cur_in  = rd_ff;
         cnt_in  = cnt_ff - POS_W'(1);
      end
      if (cmd.remove) begin
         cur_in  = rd_ff;
         left_in = left_ff - CNT_W'(1);
         rsp_in  = '{person_number: person, is_survivor: 1'b0, last: 1'b0};
      end
      if (cmd.survivor) begin
         rsp_in = '{person_number: person, is_survivor: 1'b1, last: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_write) begin
         ring_mem[idx_ff] <= init_data;
      end else if (cmd.remove) begin
         ring_mem[prev_ff] <= rd_ff;
      end
      if (cmd.prime || cmd.step || cmd.remove) begin
         rd_ff <= ring_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         cur_ff  <= '0;
         prev_ff <= '0;
         cnt_ff  <= '0;
         idx_ff  <= '0;
      end else begin
         left_ff <= left_in;
         cur_ff  <= cur_in;
         prev_ff <= prev_in;
         cnt_ff  <= cnt_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      k_ff   <= k_in;
      m_ff   <= m_in;
      rsp_ff <= rsp_in;
   end

   assign status.init_done = (idx_next == n_ff);
   assign status.cnt_zero  = (cnt_ff == '0);
   assign status.left_gt1  = (left_ff > CNT_W'(1));
   assign status.left_gt2  = (left_ff > CNT_W'(2));
   assign rsp_item         = rsp_ff;

endmodule

FILE: hw/rtl/jeo_ctrl.sv
module jeo_ctrl
   import jeo_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  jeo_status_type status,
   output jeo_cmd_type    cmd,
   output logic           busy,
   output logic           rsp_strobe
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_PRIME,
      ST_MOVE,
      ST_COUNT,
      ST_REMOVE,
      ST_SURV
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init_write = 1'b1;
            if (status.init_done) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            cmd.prime     = 1'b1;
            cmd.load_move = 1'b1;
            state_in      = ST_MOVE;
         end
         ST_MOVE: begin
            if (!status.cnt_zero) begin
               cmd.step = 1'b1;
            end else if (status.left_gt1) begin
               cmd.load_step = 1'b1;
               state_in      = ST_COUNT;
            end else begin
               state_in = ST_SURV;
            end
         end
         ST_COUNT: begin
            if (!status.cnt_zero) begin
               cmd.step = 1'b1;
            end else begin
               state_in = ST_REMOVE;
            end
         end
         ST_REMOVE: begin
            cmd.remove = 1'b1;
            if (status.left_gt2) begin
               cmd.load_step = 1'b1;
               state_in      = ST_COUNT;
            end else begin
               state_in = ST_SURV;
            end
         end
         ST_SURV: begin
            cmd.survivor = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.remove || cmd.survivor;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

FILE: hw/rtl/josephus_elimination_order_top.sv
// Sequence: with n people (after clamping), start k and step m (zero as one), a request
// fills the ring of n links, primes the read, makes k-1 moves and a check, then per
// removal makes m-1 counting steps, a check and a removal, then gives the survivor.
// Each beat shows on rsp_strobe in the cycle after it is made; the receiver cannot stall it.
// Busy stays high until the survivor is given; a new request is taken only while idle.
// Synchronous active-high reset returns the controller to idle; the ring holds no reset.
module josephus_elimination_order_top
   import jeo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_item,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   jeo_cmd_type    cmd;
   jeo_status_type status;

   // The controller sequences ring fill, the walk to the start person, and the
   // count/remove loop; it owns the strobe that marks each result beat.
   jeo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // The datapath holds the ring links in a small memory whose registered read
   // always carries the successor of the current person, so each step of the
   // walk needs a single read. It also holds the counters and the result register.
   jeo_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule

FILE: bench/elimination_order_checker.sv
module elimination_order_checker
   import jeo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   output int      failures,
   output int      pending_results,
   output int      results_checked
);

   timeunit 1ns;
   timeprecision 1ps;

   // Removal order still owed by the block, oldest beat first.
   rsp_type removal_queue[$];

   initial begin
      failures        = 0;
      pending_results = 0;
      results_checked = 0;
   end

   // Walks the ring for one request and queues every removal, then the survivor.
   function automatic void predict_removals(input req_type request);
      int next_of[MAX_PEOPLE];
      int people;
      int start_at;
      int step;
      int current;
      int previous;
      int remaining;
      rsp_type beat;

      people   = int'(request.person_count);
      start_at = int'(request.start_position);
      step     = int'(request.step_count);
      if (people == 0) people = 1;
      if (people > MAX_PEOPLE) people = MAX_PEOPLE;

      for (int i = 0; i < people; i++) begin
         next_of[i] = (i + 1 < people) ? i + 1 : 0;
      end
      current   = 0;
      previous  = people - 1;
      remaining = people;

      for (int i = 1; i < start_at; i++) begin
         previous = current;
         current  = next_of[current];
      end

      while (remaining > 1) begin
         for (int i = 1; i < step; i++) begin
            previous = current;
            current  = next_of[current];
         end
         next_of[previous] = next_of[current];
         beat.person_number = PERSON_W'(current + 1);
         beat.is_survivor   = 1'b0;
         beat.last          = 1'b0;
         removal_queue.push_back(beat);
         current   = next_of[current];
         remaining = remaining - 1;
      end

      beat.person_number = PERSON_W'(current + 1);
      beat.is_survivor   = 1'b1;
      beat.last          = 1'b1;
      removal_queue.push_back(beat);
   endfunction

   // Results are checked before a new request is queued, since a beat seen at
   // the same edge as an accepted request still belongs to the earlier one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            results_checked = results_checked + 1;
            if (removal_queue.size() == 0) begin
               failures = failures + 1;
               $display("%0t: unexpected beat, actual person %0d survivor %0b last %0b",
                        $time, rsp_item.person_number, rsp_item.is_survivor,
                        rsp_item.last);
            end else begin
               want = removal_queue.pop_front();
               if (rsp_item.person_number !== want.person_number) begin
                  failures = failures + 1;
                  $display("%0t: person_number expected %0d actual %0d",
                           $time, want.person_number, rsp_item.person_number);
               end
               if (rsp_item.is_survivor !== want.is_survivor) begin
                  failures = failures + 1;
                  $display("%0t: is_survivor expected %0b actual %0b",
                           $time, want.is_survivor, rsp_item.is_survivor);
               end
               if (rsp_item.last !== want.last) begin
                  failures = failures + 1;
                  $display("%0t: last expected %0b actual %0b",
                           $time, want.last, rsp_item.last);
               end
            end
         end
         if (start && !busy) begin
            predict_removals(req_item);
         end
      end
      pending_results = removal_queue.size();
   end

endmodule

FILE: bench/josephus_elimination_order_top_tb.sv
module josephus_elimination_order_top_tb
   import jeo_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Every input of the block is known from time zero.
   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   int failures;
   int pending_results;
   int results_checked;
   int requests_sent;
   int directed_count;

   always #5 clock = ~clock;

   josephus_elimination_order_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // The checker predicts the removal order of every accepted request and
   // compares each result beat against it; the top only drives requests.
   elimination_order_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_item        (req_item),
      .rsp_strobe      (rsp_strobe),
      .rsp_item        (rsp_item),
      .failures        (failures),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   // Issues one request beat. The task is entered right after a rising edge and
   // returns right after the edge that accepted the beat. With no idle gap the
   // start line simply stays high and only the payload changes, so start never
   // sees two assignments in one time step. Busy is looked at on the falling
   // edge, where it is stable, to decide whether the next rising edge accepts.
   task automatic send_request(input logic [5:0] people, input logic [7:0] start_at,
                               input logic [7:0] step, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                   <= 1'b1;
      req_item.person_count   <= people;
      req_item.start_position <= start_at;
      req_item.step_count     <= step;
      do @(negedge clock); while (busy);
      @(posedge clock);
      requests_sent = requests_sent + 1;
   endtask

   // Idle gaps are drawn per request, except in every other run of twenty
   // requests, which go back to back so the block is hit with no pause at all.
   function automatic int pick_gap(input int index);
      if ((index / 20) % 2 == 1) return 0;
      return $urandom_range(0, 17);
   endfunction

   initial begin
      int mode;
      logic [5:0] people;
      logic [7:0] start_at;
      logic [7:0] step;

      requests_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: the smallest and largest rings, a person count of
      // zero and one above the ring size, zero start and zero step, the largest
      // start and step, and the single-person ring with nothing to remove.
      send_request(6'd1,  8'd1,   8'd1,   pick_gap(0));
      send_request(6'd0,  8'd1,   8'd1,   pick_gap(0));
      send_request(6'd0,  8'd0,   8'd0,   pick_gap(0));
      send_request(6'd1,  8'd255, 8'd255, pick_gap(0));
      send_request(6'd2,  8'd1,   8'd1,   pick_gap(0));
      send_request(6'd2,  8'd2,   8'd2,   pick_gap(0));
      send_request(6'd5,  8'd1,   8'd2,   pick_gap(0));
      send_request(6'd7,  8'd3,   8'd3,   pick_gap(0));
      send_request(6'd10, 8'd0,   8'd3,   pick_gap(0));
      send_request(6'd10, 8'd4,   8'd0,   pick_gap(0));
      send_request(6'd6,  8'd7,   8'd1,   pick_gap(0));
      send_request(6'd9,  8'd1,   8'd10,  pick_gap(0));
      send_request(6'd32, 8'd1,   8'd1,   pick_gap(0));
      send_request(6'd32, 8'd200, 8'd2,   pick_gap(0));
      send_request(6'd32, 8'd255, 8'd255, pick_gap(0));
      send_request(6'd33, 8'd1,   8'd2,   pick_gap(0));
      send_request(6'd40, 8'd0,   8'd0,   pick_gap(0));
      send_request(6'd63, 8'd255, 8'd255, pick_gap(0));
      directed_count = requests_sent;

      // Random requests. Most use a short step so that the ring is walked many
      // times within the cycle budget; a share uses the full field ranges, and
      // another share uses tiny rings with long steps that wrap many times.
      for (int i = 0; i < 82; i++) begin
         mode = $urandom_range(0, 9);
         if (mode <= 5) begin
            people   = 6'($urandom_range(0, 63));
            start_at = 8'($urandom_range(0, 255));
            step     = 8'($urandom_range(0, 15));
         end else if (mode <= 7) begin
            people   = 6'($urandom_range(0, 63));
            start_at = 8'($urandom_range(0, 255));
            step     = 8'($urandom_range(0, 255));
         end else begin
            people   = 6'($urandom_range(1, 6));
            start_at = 8'($urandom_range(0, 255));
            step     = 8'($urandom_range(0, 255));
         end
         send_request(people, start_at, step, pick_gap(i));
      end
      start <= 1'b0;

      // Drain: wait for every predicted beat, then a short tail so that any
      // stray beat after the survivor is still caught. The count is first read
      // on a falling edge, after the checker has queued the last request.
      do @(negedge clock); while (pending_results != 0);
      repeat (32) @(posedge clock);

      $display("Sent %0d requests (%0d directed, %0d random) and checked %0d result beats.",
               requests_sent, directed_count, requests_sent - directed_count,
               results_checked);
      $display("Mismatches found: %0d.", failures);
      if (failures == 0 && pending_results == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog: several times the slowest correct run, where every request has
   // the largest ring and step and the longest idle gap before it.
   initial begin
      #60_000_000;
      $display("Timed out with %0d result beats still expected.", pending_results);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
